// ===== src/dkst_pkg.sv =====
// ----------------------------------------------------------------------------
// dkst_pkg
// Shared types and constants of the delivered key set table.
// ----------------------------------------------------------------------------
package dkst_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned HELD_W       = 7;

  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_MARK   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // level packs layer | resolution << 16 | component << 22
  typedef struct packed {
    logic [31:0] session;
    logic [47:0] tile;
    logic [35:0] level;
    logic [47:0] precinct;
  } entry_t;

  typedef struct packed {
    logic shift_all;  // whole ring moves one place toward cell 0
    logic drop;       // only the cells in front of the kept region move
    logic load;       // cell at load_idx takes the key
  } cell_ctl_t;

endpackage

// ===== src/dkst_cell.sv =====
// ----------------------------------------------------------------------------
// dkst_cell
// One entry of the key ring: holds a key, takes its neighbor's or the new key.
// ----------------------------------------------------------------------------
module dkst_cell #(
  parameter int CAPACITY = dkst_pkg::CAPACITY_DEF,
  parameter int IDX      = 0,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  dkst_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]   wr_cnt,
  input  logic [CNT_W-1:0]   load_idx,
  input  dkst_pkg::entry_t   key,
  input  dkst_pkg::entry_t   din,
  output dkst_pkg::entry_t   q
);

  dkst_pkg::entry_t entry_r;
  dkst_pkg::entry_t entry_nxt;
  logic             load_here;
  logic             part_shift;

  // during a drop step the last wr_cnt cells hold finished survivors
  always_comb begin
    load_here  = ctl.load && (load_idx == CNT_W'(IDX));
    part_shift = ctl.drop &&
                 (((CNT_W + 1)'(wr_cnt) + (CNT_W + 1)'(IDX + 1)) < (CNT_W + 1)'(CAPACITY));
    if (load_here) begin
      entry_nxt = key;
    end else if (ctl.shift_all || part_shift) begin
      entry_nxt = din;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule

// ===== src/delivered_key_set_table_top.sv =====
// ----------------------------------------------------------------------------
// delivered_key_set_table_top
// Set of delivered precinct keys held in a ring of cells.
// ----------------------------------------------------------------------------
// Input channel in_*: one transaction carries op and a ten-field key.
//   query: answer 1 if the key is stored. mark: store the key if absent,
//   answer 1, or 0 if the table is full. remove: drop every entry of
//   in_session_id, keep the order of the rest, answer 0.
// Output channel out_*: one transaction per input with answer and the
//   number of keys held afterwards.
// The entries sit in a ring of CAPACITY cells that, during a walk, rotates
// one place per cycle past a single comparator at cell 0.
// From input accept, query and mark walk the ring once and then issue
//   the result; remove also realigns the ring one place per removed entry.
//   Unused op code 3 goes straight to the result.
// One transaction at a time; in_ready is high only while idle.
// Reset empties the table at once, no clearing pass.
// A stalled output holds its result; the next input is taken meanwhile and
//   its result waits in the last state until the output register frees up.
// ----------------------------------------------------------------------------
module delivered_key_set_table_top #(
  parameter int CAPACITY = dkst_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_session_id,
  input  logic [15:0] in_tile_x,
  input  logic [15:0] in_tile_y,
  input  logic [15:0] in_tile_z,
  input  logic [15:0] in_quality_layer,
  input  logic [5:0]  in_resolution,
  input  logic [13:0] in_component,
  input  logic [15:0] in_precinct_x,
  input  logic [15:0] in_precinct_y,
  input  logic [15:0] in_precinct_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_answer,
  output logic [dkst_pkg::HELD_W-1:0] out_entries_held
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_ROT  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [IDX_W-1:0]              step_r, step_nxt;
  logic                          hit_r, hit_nxt;
  logic [CNT_W-1:0]              wr_r, wr_nxt;
  logic [CNT_W-1:0]              drops_r, drops_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          ans_r, ans_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_answer_r, out_answer_nxt;
  logic [dkst_pkg::HELD_W-1:0]   out_held_r, out_held_nxt;
  logic [1:0]                    op_r, op_nxt;
  dkst_pkg::entry_t              key_r, key_nxt;
  dkst_pkg::entry_t              key_in;
  dkst_pkg::cell_ctl_t           ctl;
  dkst_pkg::entry_t              cell_q [CAPACITY];
  logic                          in_rng;
  logic                          key_match;
  logic                          drop_now;
  logic                          last_step;

  assign key_in.session  = in_session_id;
  assign key_in.tile     = {in_tile_z, in_tile_y, in_tile_x};
  assign key_in.level    = {in_component, in_resolution, in_quality_layer};
  assign key_in.precinct = {in_precinct_z, in_precinct_y, in_precinct_x};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      dkst_cell #(
        .CAPACITY (CAPACITY),
        .IDX      (gi),
        .CNT_W    (CNT_W)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .wr_cnt   (wr_r),
        .load_idx (count_r),
        .key      (key_r),
        .din      (cell_q[(gi + 1) % CAPACITY]),
        .q        (cell_q[gi])
      );
    end
  endgenerate

  // cell 0 holds the entry whose original slot is step_r
  assign in_rng    = CNT_W'(step_r) < count_r;
  assign key_match = (cell_q[0] == key_r);
  assign drop_now  = in_rng && (cell_q[0].session == key_r.session);
  assign last_step = (step_r == IDX_W'(CAPACITY - 1));
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    hit_nxt        = hit_r;
    wr_nxt         = wr_r;
    drops_nxt      = drops_r;
    count_nxt      = count_r;
    ans_nxt        = ans_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_answer_nxt = out_answer_r;
    out_held_nxt   = out_held_r;
    ctl            = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          key_nxt   = key_in;
          step_nxt  = '0;
          hit_nxt   = 1'b0;
          wr_nxt    = '0;
          drops_nxt = '0;
          ans_nxt   = 1'b0;
          if (in_op == dkst_pkg::OP_QUERY || in_op == dkst_pkg::OP_MARK ||
              in_op == dkst_pkg::OP_REMOVE) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        step_nxt = step_r + 1'b1;
        if (op_r == dkst_pkg::OP_REMOVE) begin
          // removed entries free slots at the front, survivors collect at the back
          if (drop_now) begin
            ctl.drop  = 1'b1;
            drops_nxt = drops_r + 1'b1;
          end else begin
            ctl.shift_all = 1'b1;
            wr_nxt        = wr_r + 1'b1;
          end
        end else begin
          ctl.shift_all = 1'b1;
          hit_nxt       = hit_r || (in_rng && key_match);
        end
        if (last_step) begin
          if (op_r == dkst_pkg::OP_REMOVE) begin
            count_nxt = count_r - drops_nxt;
            ans_nxt   = 1'b0;
            state_nxt = (drops_nxt == '0) ? ST_DONE : ST_ROT;
          end else begin
            ans_nxt   = hit_nxt;
            state_nxt = ST_DONE;
            // ring is back in place after this shift; load overrides it
            if (op_r == dkst_pkg::OP_MARK && !hit_nxt &&
                count_r < CNT_W'(CAPACITY)) begin
              ctl.load  = 1'b1;
              count_nxt = count_r + 1'b1;
              ans_nxt   = 1'b1;
            end
          end
        end
      end
      ST_ROT: begin
        ctl.shift_all = 1'b1;
        drops_nxt     = drops_r - 1'b1;
        if (drops_r == CNT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_answer_nxt = ans_r;
          out_held_nxt   = dkst_pkg::HELD_W'(count_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      hit_r       <= 1'b0;
      wr_r        <= '0;
      drops_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      hit_r       <= hit_nxt;
      wr_r        <= wr_nxt;
      drops_r     <= drops_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ans_r        <= ans_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    out_answer_r <= out_answer_nxt;
    out_held_r   <= out_held_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_answer       = out_answer_r;
  assign out_entries_held = out_held_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted transaction did not start work");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result issued outside the done state");

  a_rot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT) |-> (drops_r != '0))
    else $error("realign with no removed entries");

  a_count_grows_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && op_r == dkst_pkg::OP_MARK) |=>
      (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1))
    else $error("mark changed count by more than one");

endmodule
